### hw/rtl/tpb_pkg.sv
// ----------------------------------------------------------------------------
// tpb_pkg: shared types and constants
// Widths, register indexes, command codes and state types shared by the
// tachometer period-to-bargraph block.
// ----------------------------------------------------------------------------
`default_nettype none

package tpb_pkg;

   localparam int SCALE_W     = 24;
   localparam int BAND_W      = 16;
   localparam int SPEED_W     = 16;
   localparam int BAR_W       = 16;
   localparam int CSR_INDEX_W = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND  = 4'd1;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd13107000;
   localparam logic [BAND_W-1:0]  BAND_RESET  = 16'd1000;

   // command queue between front and back
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = 2;

   // bit-serial divider: one quotient bit per cycle over the scale width
   localparam int                DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd23;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_CALC
   } cmd_op_type;

   localparam int CMD_OP_W = 2;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SPEED,
      BK_BAR,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

`default_nettype wire

### hw/rtl/tachometer_period_to_bargraph_top.sv
// ----------------------------------------------------------------------------
// tachometer_period_to_bargraph_top: input-capture tachometer with bar graph
// Counts timer ticks between capture edges, divides the scale by the period
// to get speed and drives a thermometer bar of lamps; one response per tick.
// ----------------------------------------------------------------------------
// Response path: a plain tick or wrap request passes the command queue and the
// output register; an edge with a nonzero period also waits for two passes of
// the bit-serial divider (one when speed or band is zero).
// Throughput: one request per cycle until the 4-deep command queue fills;
// each edge holds the back end for one or two divider passes.
// Reset (synchronous, active high) empties the queues, clears counter, speed
// and bar, and loads the registers with their defaults.
`default_nettype none

module tachometer_period_to_bargraph_top #(
   parameter int COUNTER_WIDTH = 16,
   parameter int LAMP_COUNT    = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   // request channel
   input  wire                              req_push,
   output logic                             req_full,
   input  wire                              req_edge_req,
   // response channel
   output logic                             rsp_empty,
   input  wire                              rsp_pop,
   output logic [tpb_pkg::SPEED_W-1:0]      rsp_speed,
   output logic [tpb_pkg::BAR_W-1:0]        rsp_bar,
   // register write channel
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [tpb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [tpb_pkg::SCALE_W-1:0]      csr_wdata
);
   import tpb_pkg::*;

   // divisor covers both the period and the band size
   localparam int DIV_W  = (COUNTER_WIDTH > BAND_W) ? COUNTER_WIDTH : BAND_W;
   localparam int CMD_W  = CMD_OP_W + COUNTER_WIDTH;

   logic [SCALE_W-1:0]       scale_ff, scale_in;
   logic [BAND_W-1:0]        band_ff, band_in;
   logic                     csr_write;

   logic                     req_accept;
   cmd_op_type               front_op;
   logic [COUNTER_WIDTH-1:0] front_period;
   logic [CMD_W-1:0]         q_wdata, q_rdata;
   logic                     q_empty, q_pop;
   cmd_op_type               cmd_op;
   logic [COUNTER_WIDTH-1:0] cmd_period;

   logic                     div_start;
   logic [SCALE_W-1:0]       div_dividend;
   logic [DIV_W-1:0]         div_divisor;
   div_sts_type              div_sts;
   logic [SCALE_W-1:0]       div_quotient;

   // Registers: always writable; unknown indexes are dropped.
   always_comb begin
      csr_ready = 1'b1;
      csr_write = csr_valid && csr_ready;
      scale_in  = scale_ff;
      band_in   = band_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SCALE: scale_in = csr_wdata;
            CSR_BAND:  band_in  = csr_wdata[BAND_W-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         band_ff  <= BAND_RESET;
      end else begin
         scale_ff <= scale_in;
         band_ff  <= band_in;
      end
   end

   // Front end: one tick per accepted request, classified into a command.
   assign req_accept = req_push && !req_full;

   tpb_front #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .edge_req (req_edge_req),
      .op       (front_op),
      .period   (front_period)
   );

   assign q_wdata = {front_op, front_period};

   // Command queue: lets ticks keep arriving while a divide runs.
   tpb_cmdq #(
      .DATA_W(CMD_W)
   ) u_cmdq (
      .clock (clock),
      .reset (reset),
      .push  (req_accept),
      .wdata (q_wdata),
      .full  (req_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign cmd_op     = cmd_op_type'(q_rdata[CMD_W-1:COUNTER_WIDTH]);
   assign cmd_period = q_rdata[COUNTER_WIDTH-1:0];

   // Shared divider: speed = scale / period, then lamps = speed / band + 1 (capped).
   tpb_div #(
      .DIV_W(DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quotient (div_quotient)
   );

   // Back end: in-order command execution and response register.
   tpb_back #(
      .COUNTER_WIDTH (COUNTER_WIDTH),
      .LAMP_COUNT    (LAMP_COUNT),
      .DIV_W         (DIV_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_empty    (q_empty),
      .cmd_op       (cmd_op),
      .cmd_period   (cmd_period),
      .cmd_pop      (q_pop),
      .scale        (scale_ff),
      .band         (band_ff),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_sts      (div_sts),
      .div_quotient (div_quotient),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_speed    (rsp_speed),
      .rsp_bar      (rsp_bar)
   );

endmodule

`default_nettype wire

### hw/rtl/tpb_front.sv
// ----------------------------------------------------------------------------
// tpb_front: tick counter and request classifier
// Counts ticks since the last capture edge and turns each request into a back
// end command: hold, clear on wrap, or compute on an edge with nonzero count.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_front #(
   parameter int COUNTER_WIDTH = 16
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       accept,
   input  wire                       edge_req,
   output tpb_pkg::cmd_op_type       op,
   output logic [COUNTER_WIDTH-1:0]  period
);
   import tpb_pkg::*;

   logic [COUNTER_WIDTH-1:0] tick_ff;
   logic [COUNTER_WIDTH-1:0] tick_in;

   always_comb begin
      period  = tick_ff;
      tick_in = tick_ff;
      op      = OP_HOLD;
      if (edge_req) begin
         if (tick_ff != '0) begin
            op = OP_CALC;
         end
         if (accept) begin
            tick_in = '0;
         end
      end else begin
         // all ones about to wrap: no edge within a full count
         if (&tick_ff) begin
            op = OP_CLEAR;
         end
         if (accept) begin
            tick_in = tick_ff + COUNTER_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else begin
         tick_ff <= tick_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/tpb_cmdq.sv
// ----------------------------------------------------------------------------
// tpb_cmdq: command queue
// Small FIFO that decouples the tick front end from the divide back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_cmdq #(
   parameter int DATA_W = 18
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire  [DATA_W-1:0] wdata,
   output logic              full,
   input  wire               pop,
   output logic [DATA_W-1:0] rdata,
   output logic              empty
);
   import tpb_pkg::*;

   logic [DATA_W-1:0]     mem_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_PTR_W:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   always_comb begin
      full      = (count_ff == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
      empty     = (count_ff == '0);
      rdata     = mem_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + CMDQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + CMDQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (CMDQ_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (CMDQ_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/tpb_div.sv
// ----------------------------------------------------------------------------
// tpb_div: bit-serial restoring divider
// Unsigned divide of a scale-wide dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_div #(
   parameter int DIV_W = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire  [tpb_pkg::SCALE_W-1:0]  dividend,
   input  wire  [DIV_W-1:0]             divisor,
   output tpb_pkg::div_sts_type         sts,
   output logic [tpb_pkg::SCALE_W-1:0]  quotient
);
   import tpb_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [SCALE_W-1:0]   quo_ff, quo_in;
   logic [DIV_W:0]       shifted;
   logic [DIV_W:0]       diff;
   logic                 ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[SCALE_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = (shifted >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_in = {quo_ff[SCALE_W-2:0], ge};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      sts.busy = busy_ff;
      sts.done = done_ff;
      quotient = quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

endmodule

`default_nettype wire

### hw/rtl/tpb_back.sv
// ----------------------------------------------------------------------------
// tpb_back: speed and bar sequencer
// Executes queued commands in order, runs the divider for speed and lamp
// count, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_back #(
   parameter int COUNTER_WIDTH = 16,
   parameter int LAMP_COUNT    = 16,
   parameter int DIV_W         = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          cmd_empty,
   input  tpb_pkg::cmd_op_type          cmd_op,
   input  wire  [COUNTER_WIDTH-1:0]     cmd_period,
   output logic                         cmd_pop,
   input  wire  [tpb_pkg::SCALE_W-1:0]  scale,
   input  wire  [tpb_pkg::BAND_W-1:0]   band,
   output logic                         div_start,
   output logic [tpb_pkg::SCALE_W-1:0]  div_dividend,
   output logic [DIV_W-1:0]             div_divisor,
   input  tpb_pkg::div_sts_type         div_sts,
   input  wire  [tpb_pkg::SCALE_W-1:0]  div_quotient,
   output logic                         rsp_empty,
   input  wire                          rsp_pop,
   output logic [tpb_pkg::SPEED_W-1:0]  rsp_speed,
   output logic [tpb_pkg::BAR_W-1:0]    rsp_bar
);
   import tpb_pkg::*;

   localparam int LW = $clog2(LAMP_COUNT + 1);

   back_state_type     state_ff, state_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [BAR_W-1:0]   bar_ff, bar_in;
   logic               out_valid_ff, out_valid_in;
   logic [SPEED_W-1:0] out_speed_ff;
   logic [BAR_W-1:0]   out_bar_ff;
   logic               can_emit;
   logic               load_out;
   logic [SPEED_W-1:0] speed_sat;
   logic [LW-1:0]      lamps;

   function automatic logic [BAR_W-1:0] bar_of(input logic [LW-1:0] n);
      logic [BAR_W-1:0] b;
      for (int i = 0; i < BAR_W; i++) begin
         b[i] = (int'(n) > i);
      end
      return b;
   endfunction

   always_comb begin
      can_emit  = !out_valid_ff || rsp_pop;
      speed_sat = (div_quotient[SCALE_W-1:SPEED_W] != '0) ? '1 :
                  div_quotient[SPEED_W-1:0];
      lamps     = (div_quotient >= SCALE_W'(LAMP_COUNT)) ? LW'(LAMP_COUNT) :
                  LW'(div_quotient) + LW'(1);

      state_in     = state_ff;
      speed_in     = speed_ff;
      bar_in       = bar_ff;
      cmd_pop      = 1'b0;
      div_start    = 1'b0;
      div_dividend = scale;
      div_divisor  = DIV_W'(cmd_period);
      load_out     = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               case (cmd_op)
                  OP_HOLD: begin
                     if (can_emit) begin
                        cmd_pop  = 1'b1;
                        load_out = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     if (can_emit) begin
                        cmd_pop  = 1'b1;
                        speed_in = '0;
                        bar_in   = '0;
                        load_out = 1'b1;
                     end
                  end
                  OP_CALC: begin
                     cmd_pop   = 1'b1;
                     div_start = 1'b1;
                     state_in  = BK_SPEED;
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         BK_SPEED: begin
            if (div_sts.done) begin
               speed_in = speed_sat;
               if (speed_sat == '0) begin
                  bar_in   = '0;
                  state_in = BK_EMIT;
               end else if (band == '0) begin
                  bar_in   = bar_of(LW'(LAMP_COUNT));
                  state_in = BK_EMIT;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = SCALE_W'(speed_sat);
                  div_divisor  = DIV_W'(band);
                  state_in     = BK_BAR;
               end
            end
         end
         BK_BAR: begin
            if (div_sts.done) begin
               bar_in   = bar_of(lamps);
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (can_emit) begin
               load_out = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      rsp_empty = !out_valid_ff;
      rsp_speed = out_speed_ff;
      rsp_bar   = out_bar_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         speed_ff     <= '0;
         bar_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         speed_ff     <= speed_in;
         bar_ff       <= bar_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_speed_ff <= speed_in;
         out_bar_ff   <= bar_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/tpb_checker.sv
// ----------------------------------------------------------------------------
// tpb_checker: port-level checks
// Watches the top level's channels for reset state, response hold and
// bar graph consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_full,
   input wire                              rsp_empty,
   input wire                              rsp_pop,
   input wire [tpb_pkg::SPEED_W-1:0]       rsp_speed,
   input wire [tpb_pkg::BAR_W-1:0]         rsp_bar
);

   // nothing pending and room for requests right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not cleared by reset");

   // a waiting response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_speed) && $stable(rsp_bar)))
      else $error("response changed while stalled");

   // bar is a thermometer code from bit 0 upward
   a_bar_thermo: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_bar & (rsp_bar + 16'd1)) == 16'd0))
      else $error("bar is not a thermometer pattern");

   // zero speed never lights a lamp, nonzero speed lights at least one
   a_bar_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_speed == 16'd0) == (rsp_bar == 16'd0)))
      else $error("bar disagrees with zero speed");

endmodule

bind tachometer_period_to_bargraph_top tpb_checker u_tpb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_speed (rsp_speed),
   .rsp_bar   (rsp_bar)
);

`default_nettype wire
